// ----- rtl/ascp_pkg.sv -----
// ----------------------------------------------------------------------------
// ascp_pkg
// Shared types and constants for the aged slot cache policy unit.
// ----------------------------------------------------------------------------
package ascp_pkg;

   localparam int SLOTS  = 6;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OP_W   = 3;
   localparam int KEY_W  = 16;
   localparam int SEL_W  = 3;
   localparam int TAG_W  = 18;
   localparam int AGE_W  = 31;

   localparam logic [AGE_W-1:0] IDLE_AGE     = AGE_W'(32'h4000_0000);
   localparam logic [AGE_W-1:0] AGE_CEIL     = AGE_W'(32'h3FFF_FFFF);
   localparam logic [TAG_W-1:0] TAG_EMPTY    = TAG_W'(18'h3FFFE);
   localparam logic [TAG_W-1:0] TAG_RESERVED = TAG_W'(18'h3FFFF);

   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd1;
   localparam logic [OP_W-1:0] OP_FILL    = 3'd2;
   localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

   typedef logic [TAG_W-1:0] tag_type;
   typedef logic [AGE_W-1:0] age_type;
   typedef logic [IDX_W-1:0] idx_type;

endpackage

// ----- rtl/ascp_if.sv -----
// ----------------------------------------------------------------------------
// ascp_if
// Request and response channels of the aged slot cache policy unit.
// ----------------------------------------------------------------------------
interface ascp_req_if;
   logic                          valid;
   logic                          ready;
   logic [ascp_pkg::OP_W-1:0]     opcode;
   logic [ascp_pkg::KEY_W-1:0]    key;
   logic [ascp_pkg::SEL_W-1:0]    slot_sel;
   logic                          any_slot;

   modport source (output valid, opcode, key, slot_sel, any_slot, input ready);
   modport sink   (input valid, opcode, key, slot_sel, any_slot, output ready);
endinterface

interface ascp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [ascp_pkg::SEL_W-1:0]    slot;
   logic                          found;

   modport source (output valid, hit, slot, found, input ready);
   modport sink   (input valid, hit, slot, found, output ready);
endinterface

// ----- rtl/aged_slot_cache_policy_unit.sv -----
// ----------------------------------------------------------------------------
// aged_slot_cache_policy_unit
// Six-slot cache directory: tag match, age-based victim pick, slot locks.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req_chan  in   valid/ready            opcode, key, slot_sel, any_slot
//  rsp_chan  out  valid/ready            hit, slot, found
//
//  One request per cycle sustained while rsp_chan does not stall; a request
//  passes through the input register, then the response register.
//  Directory state is read and updated in the cycle a request moves from
//  the input register to the response register, so requests apply in order.
//  Synchronous active-high reset empties all slots at the idle age, unlocked.
//  A stalled response holds the input register; req_chan.ready drops then if it holds a request.
// ----------------------------------------------------------------------------
module aged_slot_cache_policy_unit (
   input  logic       clock,
   input  logic       reset,
   ascp_req_if.sink   req_chan,
   ascp_rsp_if.source rsp_chan
);

   // input register
   logic                         in_valid_ff, in_valid_in;
   logic [ascp_pkg::OP_W-1:0]    op_ff;
   logic [ascp_pkg::KEY_W-1:0]   key_ff;
   logic [ascp_pkg::SEL_W-1:0]   sel_ff;
   logic                         any_ff;

   // directory state
   ascp_pkg::tag_type  tag_ff    [ascp_pkg::SLOTS];
   ascp_pkg::tag_type  tag_in    [ascp_pkg::SLOTS];
   ascp_pkg::age_type  age_ff    [ascp_pkg::SLOTS];
   ascp_pkg::age_type  age_in    [ascp_pkg::SLOTS];
   logic               locked_ff [ascp_pkg::SLOTS];
   logic               locked_in [ascp_pkg::SLOTS];

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         hit_ff, hit_in;
   logic [ascp_pkg::SEL_W-1:0]   slot_ff, slot_in;
   logic                         found_ff, found_in;

   logic               req_fire;
   logic               advance;
   logic               match_ok;
   ascp_pkg::idx_type  match_idx;
   logic               pick_ok;
   ascp_pkg::idx_type  pick_idx;
   ascp_pkg::age_type  pick_age;
   logic               ignore_locks;
   logic               sel_ok;
   ascp_pkg::idx_type  sel_idx;
   ascp_pkg::tag_type  key_tag;

   assign advance         = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !in_valid_ff || advance;
   assign req_fire        = req_chan.valid && req_chan.ready;
   assign in_valid_in     = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign key_tag      = ascp_pkg::TAG_W'(key_ff);
   assign sel_ok       = ({1'b0, sel_ff} < (ascp_pkg::SEL_W+1)'(ascp_pkg::SLOTS));
   assign sel_idx      = ascp_pkg::IDX_W'(sel_ff);
   assign ignore_locks = (op_ff == ascp_pkg::OP_LOOKUP) && any_ff;

   // first matching tag
   always_comb begin
      match_ok  = 1'b0;
      match_idx = '0;
      for (int i = ascp_pkg::SLOTS - 1; i >= 0; i--) begin
         if (tag_ff[i] == key_tag) begin
            match_ok  = 1'b1;
            match_idx = ascp_pkg::IDX_W'(i);
         end
      end
   end

   // oldest eligible slot, lowest index wins ties
   always_comb begin
      pick_ok  = 1'b0;
      pick_idx = '0;
      pick_age = '0;
      for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
         if ((ignore_locks || !locked_ff[i]) && (!pick_ok || age_ff[i] > pick_age)) begin
            pick_ok  = 1'b1;
            pick_idx = ascp_pkg::IDX_W'(i);
            pick_age = age_ff[i];
         end
      end
   end

   // next state and response
   always_comb begin
      hit_in   = 1'b0;
      slot_in  = '0;
      found_in = 1'b0;
      for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
         tag_in[i]    = tag_ff[i];
         age_in[i]    = age_ff[i];
         locked_in[i] = locked_ff[i];
      end
      case (op_ff)
         ascp_pkg::OP_TICK: begin
            for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
               if (age_ff[i] < ascp_pkg::AGE_CEIL) begin
                  age_in[i] = age_ff[i] + 1'b1;
               end
            end
         end
         ascp_pkg::OP_LOOKUP: begin
            if (match_ok) begin
               hit_in   = 1'b1;
               found_in = 1'b1;
               slot_in  = ascp_pkg::SEL_W'(match_idx);
               for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
                  if (match_idx == ascp_pkg::IDX_W'(i)) begin
                     age_in[i] = '0;
                  end
               end
            end else if (pick_ok) begin
               found_in = 1'b1;
               slot_in  = ascp_pkg::SEL_W'(pick_idx);
            end
         end
         ascp_pkg::OP_FILL: begin
            if (sel_ok) begin
               found_in = 1'b1;
               slot_in  = sel_ff;
               for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
                  if (sel_idx == ascp_pkg::IDX_W'(i)) begin
                     tag_in[i] = key_tag;
                     age_in[i] = '0;
                  end
               end
            end
         end
         ascp_pkg::OP_ACQUIRE: begin
            if (pick_ok) begin
               found_in = 1'b1;
               slot_in  = ascp_pkg::SEL_W'(pick_idx);
               for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
                  if (pick_idx == ascp_pkg::IDX_W'(i)) begin
                     tag_in[i]    = ascp_pkg::TAG_RESERVED;
                     age_in[i]    = ascp_pkg::IDLE_AGE;
                     locked_in[i] = 1'b1;
                  end
               end
            end
         end
         ascp_pkg::OP_RELEASE: begin
            if (sel_ok) begin
               found_in = 1'b1;
               slot_in  = sel_ff;
               for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
                  if (sel_idx == ascp_pkg::IDX_W'(i)) begin
                     locked_in[i] = 1'b0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && rsp_chan.ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
            tag_ff[i]    <= ascp_pkg::TAG_EMPTY;
            age_ff[i]    <= ascp_pkg::IDLE_AGE;
            locked_ff[i] <= 1'b0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
               tag_ff[i]    <= tag_in[i];
               age_ff[i]    <= age_in[i];
               locked_ff[i] <= locked_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_chan.opcode;
         key_ff <= req_chan.key;
         sel_ff <= req_chan.slot_sel;
         any_ff <= req_chan.any_slot;
      end
      if (advance) begin
         hit_ff   <= hit_in;
         slot_ff  <= slot_in;
         found_ff <= found_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit   = hit_ff;
   assign rsp_chan.slot  = slot_ff;
   assign rsp_chan.found = found_ff;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the aged slot cache policy unit. A directed table
// walks the reset state, field extremes, every defined opcode, lock exhaustion and
// out-of-range selects; random requests drawn mostly from a small key pool
// then exercise hits, victim choice and locking. Each response is compared
// with an in-bench directory model, in phases with and without random idling.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ascp_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [ascp_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam int RANDOM_PER_PHASE = 342;
   localparam int QUIET_LIMIT      = 1000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD        = 64;

   typedef struct packed {
      logic [ascp_pkg::OP_W-1:0]  opcode;
      logic [ascp_pkg::KEY_W-1:0] key;
      logic [ascp_pkg::SEL_W-1:0] slot_sel;
      logic                       any_slot;
   } dir_req_type;

   typedef struct packed {
      logic                       hit;
      logic [ascp_pkg::SEL_W-1:0] slot;
      logic                       found;
   } dir_rsp_type;

   typedef struct packed {
      dir_req_type req;
      logic        pinned;
      dir_rsp_type rsp;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;

   // pinned rows carry the response read straight off the spec
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{ascp_pkg::OP_LOOKUP,  16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b1}},
      '{'{ascp_pkg::OP_LOOKUP,  16'hFFFF, 3'd0, 1'b1}, 1'b1, '{1'b0, 3'd0, 1'b1}},
      '{'{ascp_pkg::OP_TICK,    16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{ascp_pkg::OP_FILL,    16'hFFFF, 3'd5, 1'b0}, 1'b1, '{1'b0, 3'd5, 1'b1}},
      '{'{ascp_pkg::OP_FILL,    16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b1}},
      '{'{ascp_pkg::OP_LOOKUP,  16'hFFFF, 3'd0, 1'b0}, 1'b1, '{1'b1, 3'd5, 1'b1}},
      '{'{ascp_pkg::OP_LOOKUP,  16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b1, 3'd0, 1'b1}},
      '{'{ascp_pkg::OP_FILL,    16'h1234, 3'd6, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{ascp_pkg::OP_RELEASE, 16'h0000, 3'd7, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{OP_SPARE_FIRST, 16'hFFFF, 3'd7, 1'b1}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{OP_SPARE_LAST,  16'hFFFF, 3'd7, 1'b1}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{ascp_pkg::OP_ACQUIRE, 16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd1, 1'b1}},
      '{'{ascp_pkg::OP_ACQUIRE, 16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd2, 1'b1}},
      '{'{ascp_pkg::OP_ACQUIRE, 16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd3, 1'b1}},
      '{'{ascp_pkg::OP_ACQUIRE, 16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd4, 1'b1}},
      '{'{ascp_pkg::OP_ACQUIRE, 16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b1}},
      '{'{ascp_pkg::OP_ACQUIRE, 16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd5, 1'b1}},
      '{'{ascp_pkg::OP_ACQUIRE, 16'h0000, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{ascp_pkg::OP_LOOKUP,  16'h1234, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd0, 1'b0}},
      '{'{ascp_pkg::OP_LOOKUP,  16'h1234, 3'd0, 1'b1}, 1'b1, '{1'b0, 3'd0, 1'b1}},
      '{'{ascp_pkg::OP_RELEASE, 16'h0000, 3'd3, 1'b0}, 1'b1, '{1'b0, 3'd3, 1'b1}},
      '{'{ascp_pkg::OP_LOOKUP,  16'h0007, 3'd0, 1'b0}, 1'b1, '{1'b0, 3'd3, 1'b1}},
      '{'{ascp_pkg::OP_FILL,    16'h0007, 3'd1, 1'b0}, 1'b1, '{1'b0, 3'd1, 1'b1}},
      '{'{ascp_pkg::OP_LOOKUP,  16'h0007, 3'd0, 1'b0}, 1'b0, '{1'b0, 3'd0, 1'b0}}
   };

   logic clock;
   logic reset;

   ascp_req_if req_chan ();
   ascp_rsp_if rsp_chan ();

   aged_slot_cache_policy_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // directory model
   ascp_pkg::tag_type dir_tag  [ascp_pkg::SLOTS];
   ascp_pkg::age_type dir_age  [ascp_pkg::SLOTS];
   logic              dir_lock [ascp_pkg::SLOTS];

   dir_rsp_type  expected_rsp_q [$];
   stim_row_type offered_q [$];
   logic [ascp_pkg::KEY_W-1:0] key_pool [8];

   int send_idle_pct;
   int recv_idle_pct;
   int long_hold_len;
   int quiet_cycles;
   int error_count;
   int request_count;
   int hit_count;
   int no_slot_count;

   function automatic void clear_directory();
      for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
         dir_tag[i]  = ascp_pkg::TAG_EMPTY;
         dir_age[i]  = ascp_pkg::IDLE_AGE;
         dir_lock[i] = 1'b0;
      end
   endfunction

   function automatic int oldest_slot(input logic ignore_locks);
      int best;
      best = -1;
      for (int i = 0; i < ascp_pkg::SLOTS; i++) begin
         if (ignore_locks || !dir_lock[i]) begin
            if (best < 0 || dir_age[i] > dir_age[best])
               best = i;
         end
      end
      return best;
   endfunction

   function automatic dir_rsp_type predict_directory(input dir_req_type r);
      dir_rsp_type res;
      int pick;
      res  = '0;
      pick = -1;
      case (r.opcode)
         ascp_pkg::OP_TICK: begin
            for (int i = 0; i < ascp_pkg::SLOTS; i++)
               if (dir_age[i] < ascp_pkg::AGE_CEIL)
                  dir_age[i] = dir_age[i] + 1'b1;
         end
         ascp_pkg::OP_LOOKUP: begin
            for (int i = 0; i < ascp_pkg::SLOTS; i++)
               if (pick < 0 && dir_tag[i] == ascp_pkg::TAG_W'(r.key))
                  pick = i;
            if (pick >= 0) begin
               dir_age[pick] = '0;
               res.hit = 1'b1;
            end else begin
               pick = oldest_slot(r.any_slot);
            end
            if (pick >= 0) begin
               res.found = 1'b1;
               res.slot  = ascp_pkg::SEL_W'(pick);
            end
         end
         ascp_pkg::OP_FILL: begin
            if (r.slot_sel < ascp_pkg::SLOTS) begin
               dir_tag[r.slot_sel] = ascp_pkg::TAG_W'(r.key);
               dir_age[r.slot_sel] = '0;
               res.found = 1'b1;
               res.slot  = r.slot_sel;
            end
         end
         ascp_pkg::OP_ACQUIRE: begin
            pick = oldest_slot(1'b0);
            if (pick >= 0) begin
               dir_age[pick]  = ascp_pkg::IDLE_AGE;
               dir_tag[pick]  = ascp_pkg::TAG_RESERVED;
               dir_lock[pick] = 1'b1;
               res.found = 1'b1;
               res.slot  = ascp_pkg::SEL_W'(pick);
            end
         end
         ascp_pkg::OP_RELEASE: begin
            if (r.slot_sel < ascp_pkg::SLOTS) begin
               dir_lock[r.slot_sel] = 1'b0;
               res.found = 1'b1;
               res.slot  = r.slot_sel;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic dir_req_type random_request();
      dir_req_type r;
      int roll;
      roll = $urandom_range(99);
      if (roll < 15)
         r.opcode = ascp_pkg::OP_TICK;
      else if (roll < 50)
         r.opcode = ascp_pkg::OP_LOOKUP;
      else if (roll < 70)
         r.opcode = ascp_pkg::OP_FILL;
      else if (roll < 80)
         r.opcode = ascp_pkg::OP_ACQUIRE;
      else if (roll < 95)
         r.opcode = ascp_pkg::OP_RELEASE;
      else
         r.opcode = ascp_pkg::OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
      if ($urandom_range(99) < 75)
         r.key = key_pool[$urandom_range(7)];
      else
         r.key = ascp_pkg::KEY_W'($urandom);
      if ($urandom_range(99) < 90)
         r.slot_sel = ascp_pkg::SEL_W'($urandom_range(ascp_pkg::SLOTS - 1));
      else
         r.slot_sel = ascp_pkg::SEL_W'($urandom_range(7, ascp_pkg::SLOTS));
      r.any_slot = 1'($urandom_range(1));
      return r;
   endfunction

   task automatic offer_request(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      offered_q.push_back(row);
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= row.req.opcode;
      req_chan.key      <= row.req.key;
      req_chan.slot_sel <= row.req.slot_sel;
      req_chan.any_slot <= row.req.any_slot;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   task automatic run_random(input int count, input int hold_at);
      stim_row_type row;
      row = '0;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at)
            long_hold_len = LONG_HOLD;
         row.req = random_request();
         offer_request(row);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_rsp_q.size() != 0 || offered_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_len != 0) begin
            hold_left     = long_hold_len;
            long_hold_len = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // check responses in order, then model each accepted request
   always @(posedge clock) begin
      dir_rsp_type  want;
      dir_rsp_type  got;
      dir_req_type  seen;
      stim_row_type row;
      logic         moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            got = '{rsp_chan.hit, rsp_chan.slot, rsp_chan.found};
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request pending: hit=%0d slot=%0d found=%0d",
                      got.hit, got.slot, got.found);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, got.hit);
                  error_count++;
               end
               if (got.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, got.slot);
                  error_count++;
               end
               if (got.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, got.found);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            seen = '{req_chan.opcode, req_chan.key, req_chan.slot_sel, req_chan.any_slot};
            want = predict_directory(seen);
            if (offered_q.size() != 0) begin
               row = offered_q.pop_front();
               if (row.pinned)
                  want = row.rsp;
            end
            expected_rsp_q.push_back(want);
            request_count++;
            if (want.hit)
               hit_count++;
            if ((seen.opcode == ascp_pkg::OP_LOOKUP || seen.opcode == ascp_pkg::OP_ACQUIRE)
                && !want.found)
               no_slot_count++;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("watchdog: no request or response moved for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      req_chan.valid    <= 1'b0;
      req_chan.opcode   <= ascp_pkg::OP_TICK;
      req_chan.key      <= '0;
      req_chan.slot_sel <= '0;
      req_chan.any_slot <= 1'b0;
      reset             <= 1'b1;
      send_idle_pct = 33;
      recv_idle_pct = 75;
      long_hold_len = 0;
      quiet_cycles  = 0;
      error_count   = 0;
      request_count = 0;
      hit_count     = 0;
      no_slot_count = 0;
      clear_directory();
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++)
         key_pool[i] = ascp_pkg::KEY_W'($urandom);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_request(directed_rows[i]);
      run_random(RANDOM_PER_PHASE, -1);

      wait_drained();
      send_idle_pct = 75;
      recv_idle_pct = 33;
      run_random(RANDOM_PER_PHASE, -1);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_PER_PHASE, 40);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         error_count++;
      end

      $display("Ran %0d requests (%0d directed): %0d lookup hits, %0d with no free slot.",
               request_count, DIRECTED_ROWS, hit_count, no_slot_count);
      $display("Idling 33/75, 75/33 and none, with a %0d-cycle response stall.", LONG_HOLD);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
